@@ hdl/euler_pose_converter_core_defines.svh @@
// Assertion macros for the Euler pose converter.
// Included by the RTL files that carry concurrent checks.
`ifndef EULER_POSE_CONVERTER_CORE_DEFINES_SVH
`define EULER_POSE_CONVERTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define EPC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("epc check failed");
`define EPC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("epc check failed");
`else
`define EPC_ASSERT_IMP(name, clk, rst, ante, cons)
`define EPC_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

@@ hdl/epc_pkg.sv @@
// Types, constants and the arctangent table of the Euler pose converter.
// No dependencies.
`default_nettype none
package epc_pkg;
   localparam int DP_W  = 36;
   localparam int MUL_W = 33;
   localparam int PRD_W = 2 * MUL_W;

   typedef logic signed [DP_W-1:0]  dp_type;
   typedef logic signed [MUL_W-1:0] mop_type;
   typedef logic signed [PRD_W-1:0] prd_type;

   localparam dp_type Q30_PI      = 36'sd3373259426;
   localparam dp_type Q30_HALF_PI = 36'sd1686629713;
   localparam dp_type Q30_GAIN    = 36'sd652032874;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
   localparam logic signed [15:0] PI_Q13  = 16'sd25736;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SC_START, ST_SC_RUN, ST_MUL, ST_MUL_DRAIN, ST_OUT_ROWS,
      ST_RD_SQ, ST_RD_DRAIN, ST_SQRT_GO, ST_SQRT_WAIT, ST_AT_START, ST_AT_RUN,
      ST_RD_OUT
   } epc_state_type;

   typedef enum logic [3:0] {
      S_M0, S_T1, S_T2, S_M1A, S_M1B, S_M2A, S_M2B, S_M3,
      S_M4A, S_M4B, S_M5A, S_M5B, S_M7, S_M8
   } mul_step_type;

   typedef struct packed {
      logic   start;
      logic   vectoring;
      dp_type x;
      dp_type y;
      dp_type z;
   } cordic_req_type;

   function automatic dp_type atan_entry(input logic [4:0] idx);
      dp_type v;
      begin
         case (idx)
            5'd0:  v = 36'sh03243F6A8;
            5'd1:  v = 36'sh01DAC6705;
            5'd2:  v = 36'sh00FADBAFC;
            5'd3:  v = 36'sh007F56EA6;
            5'd4:  v = 36'sh003FEAB76;
            5'd5:  v = 36'sh001FFD55B;
            5'd6:  v = 36'sh000FFFAAA;
            5'd7:  v = 36'sh0007FFF55;
            5'd8:  v = 36'sh0003FFFEA;
            5'd9:  v = 36'sh0001FFFFD;
            5'd10: v = 36'sh0000FFFFF;
            5'd11: v = 36'sh00007FFFF;
            5'd12: v = 36'sh00003FFFF;
            5'd13: v = 36'sh00001FFFF;
            5'd14: v = 36'sh00000FFFF;
            5'd15: v = 36'sh000007FFF;
            5'd16: v = 36'sh000003FFF;
            5'd17: v = 36'sh000001FFF;
            5'd18: v = 36'sh000000FFF;
            5'd19: v = 36'sh0000007FF;
            5'd20: v = 36'sh0000003FF;
            5'd21: v = 36'sh0000001FF;
            5'd22: v = 36'sh0000000FF;
            5'd23: v = 36'sh00000007F;
            default: v = '0;
         endcase
         return v;
      end
   endfunction
endpackage
`default_nettype wire

@@ hdl/epc_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on epc_pkg.
`default_nettype none
module epc_mul (
   input  wire              clock,
   input  epc_pkg::mop_type op_a,
   input  epc_pkg::mop_type op_b,
   output epc_pkg::prd_type prod_ff
);
   import epc_pkg::*;

   prd_type prod_in;

   assign prod_in = prd_type'(op_a) * prd_type'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

@@ hdl/epc_isqrt.sv @@
// Iterative floor integer square root, one result bit in each of 16 passes.
// Depends on epc_pkg.
`default_nettype none
module epc_isqrt (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [31:0] value,
   output logic        done,
   output logic [15:0] root
);
   import epc_pkg::*;

   logic [31:0] v_ff, v_in, r_ff, r_in, b_ff, b_in, rb;
   logic [3:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;

   assign rb = r_ff + b_ff;

   always_comb begin
      v_in = v_ff; r_in = r_ff; b_in = b_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      if (start) begin
         v_in = value; r_in = '0; b_in = 32'h4000_0000;
         cnt_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         if (v_ff >= rb) begin
            v_in = v_ff - rb;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign root = r_ff[15:0];
endmodule
`default_nettype wire

@@ hdl/epc_cordic.sv @@
// Shared CORDIC, rotation or vectoring, one micro-rotation per cycle.
// Depends on epc_pkg.
`default_nettype none
module epc_cordic #(
   parameter int ITERATIONS = 16
) (
   input  wire                     clock,
   input  wire                     reset,
   input  epc_pkg::cordic_req_type req,
   output logic                    done,
   output epc_pkg::dp_type         x_out,
   output epc_pkg::dp_type         y_out,
   output epc_pkg::dp_type         z_out
);
   import epc_pkg::*;

   localparam int CW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

   dp_type x_ff, x_in, y_ff, y_in, z_ff, z_in, xs, ys, at;
   logic [CW-1:0] i_ff, i_in;
   logic run_ff, run_in, done_ff, done_in, vec_ff, vec_in, pos;

   assign xs  = x_ff >>> i_ff;
   assign ys  = y_ff >>> i_ff;
   assign at  = atan_entry(5'(i_ff));
   assign pos = vec_ff ? !(y_ff > 0) : (z_ff >= 0);

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      run_in = run_ff; vec_in = vec_ff; done_in = 1'b0;
      if (req.start) begin
         x_in = req.x; y_in = req.y; z_in = req.z;
         vec_in = req.vectoring; i_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         if (pos) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == CW'(ITERATIONS - 1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         i_ff <= i_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      vec_ff <= vec_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule
`default_nettype wire

@@ hdl/euler_pose_converter_core.sv @@
// Top level of the Euler pose converter: sequencer, pose store, datapath glue.
// Depends on epc_pkg, epc_cordic, epc_isqrt, epc_mul and the defines header.
// One transaction at a time. A set transaction runs three sine/cosine CORDIC
// passes, then its products on the shared multiplier, then offers three row
// results. A read transaction squares two entries on the multiplier, runs
// the square root and two or three atan2 CORDIC passes, then offers one
// result. The CORDIC loop sets the rate; req_stall is high from acceptance
// until the last result is taken.
`default_nettype none
`include "euler_pose_converter_core_defines.svh"
module euler_pose_converter_core #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_func,
   input  wire  signed [23:0] req_trans_x,
   input  wire  signed [23:0] req_trans_y,
   input  wire  signed [23:0] req_trans_z,
   input  wire  signed [15:0] req_roll_in,
   input  wire  signed [15:0] req_pitch_in,
   input  wire  signed [15:0] req_yaw_in,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic        [1:0]  rsp_row_index,
   output logic signed [15:0] rsp_rot_col0,
   output logic signed [15:0] rsp_rot_col1,
   output logic signed [15:0] rsp_rot_col2,
   output logic signed [23:0] rsp_trans_out,
   output logic signed [15:0] rsp_roll_out,
   output logic signed [15:0] rsp_pitch_out,
   output logic signed [15:0] rsp_yaw_out,
   output logic               rsp_singular_flag,
   output logic               rsp_last,
   input  wire                csr_wr_en,
   input  wire         [14:0] csr_wr_data
);
   import epc_pkg::*;

   function automatic dp_type rnd30(input prd_type p);
      prd_type t;
      begin
         t = (p + (prd_type'(1) <<< 29)) >>> 30;
         return dp_type'(t);
      end
   endfunction

   function automatic logic signed [15:0] to_q14(input dp_type v);
      dp_type t;
      begin
         t = (v + (dp_type'(1) <<< 15)) >>> 16;
         if (t > dp_type'(ONE_Q14)) return ONE_Q14;
         else if (t < -dp_type'(ONE_Q14)) return -ONE_Q14;
         else return 16'(t);
      end
   endfunction

   function automatic logic signed [15:0] to_ang(input dp_type v);
      dp_type t;
      begin
         t = (v + (dp_type'(1) <<< 16)) >>> 17;
         if (t > dp_type'(PI_Q13)) return PI_Q13;
         else if (t < -dp_type'(PI_Q13)) return -PI_Q13;
         else return 16'(t);
      end
   endfunction

   epc_state_type state_ff, state_in;
   mul_step_type  step_ff, ptag_ff;
   logic [1:0]    job_ff, row_ff;
   logic          func_ff, pvld_ff, neg_ff, zero_ff, sing_ff;
   logic signed [15:0] ang_ff [3];
   logic signed [23:0] trans_ff [3];
   logic signed [15:0] rot_ff [9];
   logic [14:0]   thr_ff;
   mop_type       sin_ff [3];
   mop_type       cos_ff [3];
   dp_type        t1_ff, t2_ff, acc_ff;
   logic [31:0]   sq_ff;
   logic [15:0]   sy_ff;
   logic signed [15:0] roll_ff, pitch_ff, yaw_ff;

   logic accept;
   mop_type op_a, op_b;
   prd_type prod;
   dp_type  pr;
   cordic_req_type creq;
   logic    c_done, s_done, sqrt_go;
   dp_type  c_x, c_y, c_z;
   logic [15:0] s_root;
   dp_type  sc_z, at_x, at_y, at_z;
   logic signed [17:0] yv, xv;
   logic    sc_neg, at_zero;

   assign accept = req_valid && !req_stall;
   assign pr = rnd30(prod);

   epc_mul u_mul (.clock(clock), .op_a(op_a), .op_b(op_b), .prod_ff(prod));

   epc_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock(clock), .reset(reset), .req(creq), .done(c_done),
      .x_out(c_x), .y_out(c_y), .z_out(c_z)
   );

   epc_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sqrt_go), .value(sq_ff),
      .done(s_done), .root(s_root)
   );

   // angle reduction for sine/cosine
   always_comb begin
      sc_z = dp_type'(ang_ff[job_ff]) <<< 17;
      sc_neg = 1'b0;
      if (sc_z > Q30_HALF_PI) begin
         sc_z = sc_z - Q30_PI; sc_neg = 1'b1;
      end else if (sc_z < -Q30_HALF_PI) begin
         sc_z = sc_z + Q30_PI; sc_neg = 1'b1;
      end
   end

   // atan2 operand selection and quadrant fold
   always_comb begin
      case (job_ff)
         2'd0: begin
            yv = -18'(rot_ff[6]); xv = 18'(sy_ff);
         end
         2'd1: begin
            if (sing_ff) begin
               yv = -18'(rot_ff[5]); xv = 18'(rot_ff[4]);
            end else begin
               yv = 18'(rot_ff[7]); xv = 18'(rot_ff[8]);
            end
         end
         default: begin
            yv = 18'(rot_ff[3]); xv = 18'(rot_ff[0]);
         end
      endcase
      at_zero = (xv == 0) && (yv == 0);
      at_x = dp_type'(xv) <<< 16;
      at_y = dp_type'(yv) <<< 16;
      at_z = '0;
      if (at_x < 0) begin
         at_z = (at_y >= 0) ? Q30_PI : -Q30_PI;
         at_x = -at_x;
         at_y = -at_y;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (accept) state_in = req_func ? ST_RD_SQ : ST_SC_START;
         ST_SC_START:  state_in = ST_SC_RUN;
         ST_SC_RUN:    if (c_done) state_in = (job_ff == 2'd2) ? ST_MUL : ST_SC_START;
         ST_MUL:       if (step_ff == S_M8) state_in = ST_MUL_DRAIN;
         ST_MUL_DRAIN: state_in = ST_OUT_ROWS;
         ST_OUT_ROWS:  if (!rsp_stall && row_ff == 2'd2) state_in = ST_IDLE;
         ST_RD_SQ:     if (step_ff == S_T1) state_in = ST_RD_DRAIN;
         ST_RD_DRAIN:  state_in = ST_SQRT_GO;
         ST_SQRT_GO:   state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: if (s_done) state_in = ST_AT_START;
         ST_AT_START:  state_in = ST_AT_RUN;
         ST_AT_RUN: begin
            if (c_done) begin
               if (job_ff == 2'd2 || (job_ff == 2'd1 && sing_ff)) state_in = ST_RD_OUT;
               else state_in = ST_AT_START;
            end
         end
         ST_RD_OUT:    if (!rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT_ROWS) || (state_ff == ST_RD_OUT);
      sqrt_go = (state_ff == ST_SQRT_GO);
      creq = '0;
      if (state_ff == ST_SC_START) begin
         creq.start = 1'b1;
         creq.x = Q30_GAIN;
         creq.z = sc_z;
      end else if (state_ff == ST_AT_START) begin
         creq.start = 1'b1;
         creq.vectoring = 1'b1;
         creq.x = at_x;
         creq.y = at_y;
         creq.z = at_z;
      end
      op_a = '0;
      op_b = '0;
      if (state_ff == ST_RD_SQ) begin
         op_a = (step_ff == S_M0) ? mop_type'(rot_ff[0]) : mop_type'(rot_ff[3]);
         op_b = op_a;
      end else if (state_ff == ST_MUL) begin
         case (step_ff)
            S_M0:  begin op_a = cos_ff[2]; op_b = cos_ff[1]; end
            S_T1:  begin op_a = cos_ff[2]; op_b = sin_ff[1]; end
            S_T2:  begin op_a = sin_ff[2]; op_b = sin_ff[1]; end
            S_M1A: begin op_a = mop_type'(t1_ff); op_b = sin_ff[0]; end
            S_M1B: begin op_a = sin_ff[2]; op_b = cos_ff[0]; end
            S_M2A: begin op_a = mop_type'(t1_ff); op_b = cos_ff[0]; end
            S_M2B: begin op_a = sin_ff[2]; op_b = sin_ff[0]; end
            S_M3:  begin op_a = sin_ff[2]; op_b = cos_ff[1]; end
            S_M4A: begin op_a = mop_type'(t2_ff); op_b = sin_ff[0]; end
            S_M4B: begin op_a = cos_ff[2]; op_b = cos_ff[0]; end
            S_M5A: begin op_a = mop_type'(t2_ff); op_b = cos_ff[0]; end
            S_M5B: begin op_a = cos_ff[2]; op_b = sin_ff[0]; end
            S_M7:  begin op_a = cos_ff[1]; op_b = sin_ff[0]; end
            S_M8:  begin op_a = cos_ff[1]; op_b = cos_ff[0]; end
            default: begin op_a = '0; op_b = '0; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= S_M0;
         ptag_ff <= S_M0;
         pvld_ff <= 1'b0;
         job_ff <= '0;
         row_ff <= '0;
         thr_ff <= 15'd1;
         for (int k = 0; k < 9; k++) rot_ff[k] <= (k % 4 == 0) ? ONE_Q14 : '0;
         for (int k = 0; k < 3; k++) trans_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         pvld_ff <= (state_ff == ST_MUL) || (state_ff == ST_RD_SQ);
         ptag_ff <= step_ff;
         if (csr_wr_en) thr_ff <= csr_wr_data;
         if (accept) begin
            job_ff <= '0;
            row_ff <= '0;
            step_ff <= S_M0;
            if (!req_func) begin
               trans_ff[0] <= req_trans_x;
               trans_ff[1] <= req_trans_y;
               trans_ff[2] <= req_trans_z;
            end
         end
         if (state_ff == ST_MUL || state_ff == ST_RD_SQ)
            step_ff <= mul_step_type'(step_ff + 4'd1);
         if (state_ff == ST_SC_RUN && c_done) job_ff <= job_ff + 2'd1;
         if (state_ff == ST_AT_RUN && c_done) job_ff <= job_ff + 2'd1;
         if (state_ff == ST_SQRT_WAIT) job_ff <= '0;
         if (state_ff == ST_OUT_ROWS && !rsp_stall) row_ff <= row_ff + 2'd1;
         if (pvld_ff && !func_ff) begin
            case (ptag_ff)
               S_M0:  rot_ff[0] <= to_q14(pr);
               S_M1B: rot_ff[1] <= to_q14(acc_ff - pr);
               S_M2B: rot_ff[2] <= to_q14(acc_ff + pr);
               S_M3:  rot_ff[3] <= to_q14(pr);
               S_M4B: rot_ff[4] <= to_q14(acc_ff + pr);
               S_M5B: rot_ff[5] <= to_q14(acc_ff - pr);
               S_M7:  rot_ff[7] <= to_q14(pr);
               S_M8:  rot_ff[8] <= to_q14(pr);
               default: ;
            endcase
         end
         if (state_ff == ST_MUL_DRAIN) rot_ff[6] <= to_q14(-dp_type'(sin_ff[1]));
      end
      if (accept) begin
         func_ff <= req_func;
         ang_ff[0] <= req_roll_in;
         ang_ff[1] <= req_pitch_in;
         ang_ff[2] <= req_yaw_in;
         sq_ff <= '0;
         yaw_ff <= '0;
      end
      if (state_ff == ST_SC_START) neg_ff <= sc_neg;
      if (state_ff == ST_AT_START) zero_ff <= at_zero;
      if (state_ff == ST_SC_RUN && c_done) begin
         sin_ff[job_ff] <= neg_ff ? mop_type'(-c_y) : mop_type'(c_y);
         cos_ff[job_ff] <= neg_ff ? mop_type'(-c_x) : mop_type'(c_x);
      end
      if (pvld_ff && !func_ff) begin
         case (ptag_ff)
            S_T1:  t1_ff <= pr;
            S_T2:  t2_ff <= pr;
            S_M1A: acc_ff <= pr;
            S_M2A: acc_ff <= pr;
            S_M4A: acc_ff <= pr;
            S_M5A: acc_ff <= pr;
            default: ;
         endcase
      end
      if (pvld_ff && func_ff) sq_ff <= sq_ff + prod[31:0];
      if (state_ff == ST_SQRT_WAIT && s_done) begin
         sy_ff <= s_root;
         sing_ff <= (s_root < {1'b0, thr_ff});
      end
      if (state_ff == ST_AT_RUN && c_done) begin
         case (job_ff)
            2'd0:    pitch_ff <= zero_ff ? '0 : to_ang(c_z);
            2'd1:    roll_ff <= zero_ff ? '0 : to_ang(c_z);
            default: yaw_ff <= zero_ff ? '0 : to_ang(c_z);
         endcase
      end
   end

   // result fields
   always_comb begin
      rsp_row_index = '0;
      rsp_rot_col0 = '0;
      rsp_rot_col1 = '0;
      rsp_rot_col2 = '0;
      rsp_trans_out = '0;
      rsp_roll_out = '0;
      rsp_pitch_out = '0;
      rsp_yaw_out = '0;
      rsp_singular_flag = 1'b0;
      rsp_last = 1'b0;
      if (state_ff == ST_RD_OUT) begin
         rsp_roll_out = roll_ff;
         rsp_pitch_out = pitch_ff;
         rsp_yaw_out = yaw_ff;
         rsp_singular_flag = sing_ff;
         rsp_last = 1'b1;
      end else begin
         rsp_row_index = row_ff;
         rsp_last = (row_ff == 2'd2);
         case (row_ff)
            2'd0: begin
               rsp_rot_col0 = rot_ff[0]; rsp_rot_col1 = rot_ff[1];
               rsp_rot_col2 = rot_ff[2]; rsp_trans_out = trans_ff[0];
            end
            2'd1: begin
               rsp_rot_col0 = rot_ff[3]; rsp_rot_col1 = rot_ff[4];
               rsp_rot_col2 = rot_ff[5]; rsp_trans_out = trans_ff[1];
            end
            default: begin
               rsp_rot_col0 = rot_ff[6]; rsp_rot_col1 = rot_ff[7];
               rsp_rot_col2 = rot_ff[8]; rsp_trans_out = trans_ff[2];
            end
         endcase
      end
   end

   `EPC_ASSERT_IMP(a_busy_while_valid, clock, reset, rsp_valid, req_stall)
   `EPC_ASSERT_IMP(a_sing_yaw_zero, clock, reset, rsp_valid && rsp_singular_flag, rsp_yaw_out == 0)
   `EPC_ASSERT_NXT(a_last_to_idle, clock, reset, rsp_valid && rsp_last && !rsp_stall, !req_stall)
   `EPC_ASSERT_IMP(a_read_single, clock, reset, state_ff == ST_RD_OUT, rsp_last && rsp_row_index == 0)
endmodule
`default_nettype wire
